// ----- src/ate_pkg.sv -----
// Package for the ANSI text console engine: payload structs, action codes,
// escape phases, grid geometry and the SGR colour table.
// No dependencies; every other file imports it.
`default_nettype none

package ate_pkg;

  localparam int COLUMNS     = 32;
  localparam int ROWS        = 24;
  localparam int MAX_RESULTS = 4;

  localparam logic [1:0] ACT_ATTR   = 2'd0;
  localparam logic [1:0] ACT_GLYPH  = 2'd1;
  localparam logic [1:0] ACT_SCROLL = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [7:0] ATTR_DEFAULT = 8'h38;
  localparam logic [7:0] ATTR_FLASH   = 8'h80;
  localparam logic [7:0] ATTR_BRIGHT  = 8'h40;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRKT = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_GOT_ESC = 2'd1,
    ESC_GOT_CSI = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] column;
    logic [4:0] row;
    logic [7:0] glyph_code;
    logic [7:0] attr_value;
    logic       last;
  } result_t;

  // Up to four results produced by one request, with their count.
  typedef struct packed {
    logic [2:0]                     count;
    result_t [MAX_RESULTS-1:0]      res;
  } bundle_t;

  function automatic result_t make_result(input logic [1:0] action,
                                          input logic [4:0] column,
                                          input logic [4:0] row,
                                          input logic [7:0] glyph,
                                          input logic [7:0] attr);
    result_t r;
    r.action     = action;
    r.column     = column;
    r.row        = row;
    r.glyph_code = glyph;
    r.attr_value = attr;
    r.last       = 1'b0;
    return r;
  endfunction

  // ANSI colour order mapped to the attribute colour numbers.
  function automatic logic [2:0] sgr_colour(input logic [2:0] idx);
    logic [2:0] c;
    case (idx)
      3'd0: c = 3'd0;
      3'd1: c = 3'd2;
      3'd2: c = 3'd4;
      3'd3: c = 3'd6;
      3'd4: c = 3'd1;
      3'd5: c = 3'd3;
      3'd6: c = 3'd5;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/ate_core.sv -----
// Console state registers and the single-pass decode of one request into
// its list of results. Depends on ate_pkg.
`default_nettype none

module ate_core (
  input  wire             clk,
  input  wire             rst_n,
  input  ate_pkg::item_t  item,
  input  wire             fire,
  input  wire             cursor_on,
  output ate_pkg::bundle_t bundle
);
  import ate_pkg::*;

  localparam logic [5:0] COL_LIMIT = 6'(COLUMNS);
  localparam logic [5:0] ROW_LIMIT = 6'(ROWS);
  localparam logic [4:0] ROW_LAST  = 5'(ROWS - 1);

  logic [4:0] col_r, col_nxt;
  logic [4:0] row_r, row_nxt;
  logic [7:0] attr_r, attr_nxt;
  esc_phase_t phase_r, phase_nxt;
  logic [7:0] acc_r, acc_nxt;

  always_comb begin
    logic [5:0]  x;
    logic [5:0]  y;
    logic [2:0]  n;
    logic [2:0]  n_m1;
    logic [11:0] v;
    logic [7:0]  code_lo;
    logic [7:0]  a;
    result_t [MAX_RESULTS-1:0] res;

    col_nxt   = col_r;
    row_nxt   = row_r;
    attr_nxt  = attr_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    x         = {1'b0, col_r};
    y         = {1'b0, row_r};
    n         = 3'd0;
    v         = 12'd0;
    code_lo   = 8'd0;
    a         = attr_r;
    res       = '0;

    if (item.func) begin
      col_nxt   = 5'd0;
      row_nxt   = 5'd0;
      attr_nxt  = ATTR_DEFAULT;
      phase_nxt = ESC_IDLE;
      acc_nxt   = 8'd0;
      res[0] = make_result(ACT_CLEAR, 5'd0, 5'd0, 8'd0, ATTR_DEFAULT);
      n = 3'd1;
      if (cursor_on) begin
        res[1] = make_result(ACT_ATTR, 5'd0, 5'd0, 8'd0, ATTR_DEFAULT | ATTR_FLASH);
        n = 3'd2;
      end
    end else if (phase_r == ESC_GOT_ESC) begin
      if (item.char_code == CH_LBRKT) begin
        phase_nxt = ESC_GOT_CSI;
        acc_nxt   = 8'd0;
      end else begin
        phase_nxt = ESC_IDLE;
      end
    end else if (phase_r != ESC_IDLE) begin
      if (item.char_code == CH_M) begin
        phase_nxt = ESC_IDLE;
        if (acc_r >= 8'd30 && acc_r <= 8'd37) begin
          code_lo = acc_r - 8'd30;
        end else begin
          code_lo = acc_r - 8'd40;
        end
        case (acc_r) inside
          8'd0:          a = ATTR_DEFAULT;
          8'd1:          a = attr_r | ATTR_BRIGHT;
          8'd2:          a = attr_r & ~ATTR_BRIGHT;
          8'd5:          a = attr_r | ATTR_FLASH;
          8'd25:         a = attr_r & ~ATTR_FLASH;
          [8'd30:8'd37]: a = {attr_r[7:3], sgr_colour(code_lo[2:0])};
          8'd39:         a = {attr_r[7:3], 3'd0};
          [8'd40:8'd47]: a = {attr_r[7:6], sgr_colour(code_lo[2:0]), attr_r[2:0]};
          8'd49:         a = {attr_r[7:6], 3'd0, attr_r[2:0]};
          default:       a = attr_r;
        endcase
        attr_nxt = a;
      end else if (item.char_code >= CH_ZERO && item.char_code <= CH_NINE) begin
        v = 12'(acc_r) * 12'd10 + {4'd0, item.char_code - CH_ZERO};
        acc_nxt = (v > 12'd255) ? 8'd255 : v[7:0];
      end else begin
        phase_nxt = ESC_IDLE;
      end
    end else begin
      // Restore the old cursor cell with the plain attribute first.
      res[0] = make_result(ACT_ATTR, col_r, row_r, 8'd0, attr_r);
      n = 3'd1;
      if (item.char_code == CH_LF) begin
        y = y + 6'd1;
        x = 6'd0;
      end else if (item.char_code == CH_CR) begin
        x = 6'd0;
      end else if (item.char_code == CH_ESC) begin
        phase_nxt = ESC_GOT_ESC;
      end else begin
        res[1] = make_result(ACT_GLYPH, col_r, row_r, item.char_code, 8'd0);
        n = 3'd2;
        x = x + 6'd1;
      end
      if (x >= COL_LIMIT) begin
        x = 6'd0;
        y = y + 6'd1;
      end
      if (y >= ROW_LIMIT) begin
        res[n[1:0]] = make_result(ACT_SCROLL, 5'd0, 5'd0, 8'd0, 8'd0);
        n = n + 3'd1;
        y = {1'b0, ROW_LAST};
      end
      col_nxt = x[4:0];
      row_nxt = y[4:0];
      if (cursor_on) begin
        res[n[1:0]] = make_result(ACT_ATTR, x[4:0], y[4:0], 8'd0, attr_r | ATTR_FLASH);
        n = n + 3'd1;
      end
    end

    n_m1 = n - 3'd1;
    if (n != 3'd0) begin
      res[n_m1[1:0]].last = 1'b1;
    end
    bundle.count = n;
    bundle.res   = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= 5'd0;
      row_r   <= 5'd0;
      attr_r  <= ATTR_DEFAULT;
      phase_r <= ESC_IDLE;
      acc_r   <= 8'd0;
    end else if (fire) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      attr_r  <= attr_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/ate_serializer.sv -----
// Result register: holds one request's result list and hands it out one
// result per cycle on the output channel unless stalled. Depends on ate_pkg.
`default_nettype none

module ate_serializer (
  input  wire               clk,
  input  wire               rst_n,
  input  ate_pkg::bundle_t  bundle,
  input  wire               load,
  output logic              free,
  output logic              out_valid,
  input  wire               out_stall,
  output ate_pkg::result_t  out_data
);
  import ate_pkg::*;

  result_t [MAX_RESULTS-1:0] res_r;
  logic [2:0] count_r;
  logic [1:0] idx_r;
  logic       last_slot;

  assign out_valid = (count_r != 3'd0);
  assign out_data  = res_r[idx_r];
  assign last_slot = (({1'b0, idx_r} + 3'd1) == count_r);
  assign free      = !out_valid || (!out_stall && last_slot);

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= bundle.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
      idx_r   <= 2'd0;
    end else if (load) begin
      count_r <= bundle.count;
      idx_r   <= 2'd0;
    end else if (out_valid && !out_stall) begin
      if (last_slot) begin
        count_r <= 3'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result list loaded while results still pending");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, idx_r} < count_r))
    else $error("result index beyond list length");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == last_slot))
    else $error("last flag does not match final result of the list");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(MAX_RESULTS))
    else $error("result count exceeds list capacity");

endmodule

`default_nettype wire

// ----- src/ansi_text_console_engine_unit.sv -----
// Top level of the ANSI text console engine: input register, console core
// and result serializer. Depends on ate_pkg, ate_core and ate_serializer.
//
// The input channel (in_valid, in_stall, in_data) takes one request per
// accepting edge: a character byte or a clear command. The output channel
// (out_valid, out_stall, out_data) carries attribute writes, glyph draws,
// scroll-up and clear commands. Each input request yields zero to four
// results, the final one flagged by last; bytes inside an escape sequence
// yield none. The configuration channel (cfg_valid, cfg_ready,
// cfg_cursor_on) writes the cursor enable; cfg_ready is always high.
// A request is held in the input register, where the core decodes it in
// one pass; its result list is then registered in the serializer, which
// drives the first result. Results leave one per cycle while out_stall is
// low, at most 4 per item, and bytes inside an escape sequence pass at one
// per cycle.
// Reset puts the console in the post-clear state (cursor at 0,0, attribute
// 0x38, no escape) with the cursor enabled. While out_stall is high the
// current result holds; one further request that yields results waits in
// the input register with in_stall high until the result list drains.
`default_nettype none

module ansi_text_console_engine_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  ate_pkg::item_t    in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output ate_pkg::result_t  out_data,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire               cfg_cursor_on
);
  import ate_pkg::*;

  item_t   item_r;
  logic    item_valid_r;
  logic    cursor_on_r;
  bundle_t bundle;
  logic    ser_free;
  logic    advance;
  logic    load;

  // The held request moves on when it yields no result or when the
  // serializer can take its result list this cycle.
  assign advance  = item_valid_r && ((bundle.count == 3'd0) || ser_free);
  assign load     = advance && (bundle.count != 3'd0);
  assign in_stall = item_valid_r && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_on_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      cursor_on_r <= cfg_cursor_on;
    end
  end

  ate_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item_r),
    .fire      (advance),
    .cursor_on (cursor_on_r),
    .bundle    (bundle)
  );

  ate_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .bundle    (bundle),
    .load      (load),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
